>>> rtl/fsme_pkg.sv
`timescale 1ns / 1ps

package fsme_pkg;

    // Default sizes handed down through the top-level parameters.
    localparam int TABLE_DEPTH_DEF = 256;
    localparam int STATE_BITS_DEF  = 8;

    // Fixed widths of the beat fields.
    localparam int LETTER_W    = 8;
    localparam int NEW_STATE_W = 8;
    localparam int FIELD_W     = 8;
    localparam int MODE_W      = 2;

    // Item kinds carried in the slave-side tuser.
    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD    = 2'd0,
        MODE_STEP    = 2'd1,
        MODE_RESTART = 2'd2
    } t_mode;

    // ASCII codes used for the letter check and case folding.
    localparam logic [LETTER_W-1:0] CH_UPPER_A  = 8'h41;
    localparam logic [LETTER_W-1:0] CH_UPPER_Z  = 8'h5A;
    localparam logic [LETTER_W-1:0] CH_LOWER_A  = 8'h61;
    localparam logic [LETTER_W-1:0] CH_LOWER_Z  = 8'h7A;
    localparam logic [LETTER_W-1:0] CASE_OFFSET = 8'h20;

    // One result beat, new_state in the lowest bits.
    typedef struct packed {
        logic                   table_full;
        logic                   bad_letter;
        logic                   matched;
        logic [NEW_STATE_W-1:0] new_state;
    } t_result;

    localparam int RESULT_W = $bits(t_result);
    localparam int OUT_DATA_W = ((RESULT_W + 7) / 8) * 8;

    // True for A-Z and a-z only.
    function automatic logic is_letter(input logic [LETTER_W-1:0] c);
        return ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ||
               ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z));
    endfunction

    // Folds A-Z to a-z and leaves every other code alone.
    function automatic logic [LETTER_W-1:0] fold_lower(input logic [LETTER_W-1:0] c);
        logic [LETTER_W-1:0] r;
        r = c;
        if ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) begin
            r = c + CASE_OFFSET;
        end
        return r;
    endfunction

endpackage

>>> rtl/fsme_row_mem.sv
`timescale 1ns / 1ps

module fsme_row_mem #(
    parameter int DEPTH = fsme_pkg::TABLE_DEPTH_DEF,
    parameter int WIDTH = 2 * fsme_pkg::STATE_BITS_DEF + fsme_pkg::LETTER_W,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Single write port; contents are not cleared by reset.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/fsme_engine.sv
`timescale 1ns / 1ps

module fsme_engine #(
    parameter int TABLE_DEPTH = fsme_pkg::TABLE_DEPTH_DEF,
    parameter int STATE_BITS  = fsme_pkg::STATE_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  fsme_pkg::t_mode                   i_mode,
    input  logic [fsme_pkg::LETTER_W-1:0]     i_letter,
    input  logic [fsme_pkg::FIELD_W-1:0]      i_from,
    input  logic [fsme_pkg::FIELD_W-1:0]      i_to,
    output logic                              o_ready,
    output logic                              o_res_valid,
    output fsme_pkg::t_result                 o_res,
    input  logic                              i_res_take
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int LW = fsme_pkg::LETTER_W;
    localparam int RW = 2 * STATE_BITS + LW;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } t_eng_state;

    t_eng_state r_fsm, n_fsm;

    logic [STATE_BITS-1:0] r_cur, n_cur;
    logic [CW-1:0]         r_count, n_count;
    logic [CW-1:0]         r_issue, n_issue;
    logic [LW-1:0]         r_letter, n_letter;
    logic [LW-1:0]         r_low, n_low;
    logic                  r_matched, n_matched;
    logic                  r_bad, n_bad;
    logic                  r_full, n_full;

    logic [STATE_BITS-1:0] w_from;
    logic [STATE_BITS-1:0] w_to;
    logic                  w_wr_en;
    logic                  w_rd_en;
    logic [AW-1:0]         w_rd_addr;
    logic [RW-1:0]         w_wr_data;
    logic [RW-1:0]         w_rd_data;
    logic [STATE_BITS-1:0] w_row_from;
    logic [LW-1:0]         w_row_letter;
    logic [STATE_BITS-1:0] w_row_to;
    logic                  w_hit;

    // Row states keep only their low STATE_BITS bits; narrower fields are zero-extended.
    for (genvar g = 0; g < STATE_BITS; g++) begin : g_state_in
        if (g < fsme_pkg::FIELD_W) begin : g_bit
            assign w_from[g] = i_from[g];
            assign w_to[g]   = i_to[g];
        end else begin : g_pad
            assign w_from[g] = 1'b0;
            assign w_to[g]   = 1'b0;
        end
    end

    // The result shows the low eight bits of the current state.
    for (genvar g = 0; g < fsme_pkg::NEW_STATE_W; g++) begin : g_state_out
        if (g < STATE_BITS) begin : g_bit
            assign o_res.new_state[g] = r_cur[g];
        end else begin : g_pad
            assign o_res.new_state[g] = 1'b0;
        end
    end

    assign o_res.matched    = r_matched;
    assign o_res.bad_letter = r_bad;
    assign o_res.table_full = r_full;
    assign o_res_valid      = (r_fsm == ST_DONE);
    assign o_ready          = (r_fsm == ST_IDLE);

    // Row layout: from-state lowest, then letter, then to-state.
    assign w_wr_data    = {w_to, i_letter, w_from};
    assign w_row_from   = w_rd_data[STATE_BITS-1:0];
    assign w_row_letter = w_rd_data[STATE_BITS +: LW];
    assign w_row_to     = w_rd_data[STATE_BITS + LW +: STATE_BITS];
    assign w_hit        = (w_row_from == r_cur) &&
                          ((w_row_letter == r_letter) || (w_row_letter == r_low));

    assign w_rd_addr = (r_fsm == ST_IDLE) ? '0 : r_issue[AW-1:0];

    fsme_row_mem #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (RW),
        .AW    (AW)
    ) u_row_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // Sequencer: the scan reads one row a cycle and compares the row read the cycle before.
    always_comb begin
        n_fsm     = r_fsm;
        n_cur     = r_cur;
        n_count   = r_count;
        n_issue   = r_issue;
        n_letter  = r_letter;
        n_low     = r_low;
        n_matched = r_matched;
        n_bad     = r_bad;
        n_full    = r_full;
        w_wr_en   = 1'b0;
        w_rd_en   = 1'b0;
        unique case (r_fsm)
            ST_IDLE: begin
                if (i_valid) begin
                    n_matched = 1'b0;
                    n_bad     = 1'b0;
                    n_full    = 1'b0;
                    n_fsm     = ST_DONE;
                    case (i_mode)
                        fsme_pkg::MODE_LOAD: begin
                            if (r_count < CW'(TABLE_DEPTH)) begin
                                w_wr_en = 1'b1;
                                n_count = r_count + CW'(1);
                            end else begin
                                n_full = 1'b1;
                            end
                        end
                        fsme_pkg::MODE_STEP: begin
                            if (!fsme_pkg::is_letter(i_letter)) begin
                                n_bad = 1'b1;
                            end else if (r_count != '0) begin
                                w_rd_en  = 1'b1;
                                n_issue  = CW'(1);
                                n_letter = i_letter;
                                n_low    = fsme_pkg::fold_lower(i_letter);
                                n_fsm    = ST_SCAN;
                            end
                        end
                        fsme_pkg::MODE_RESTART: begin
                            n_count = '0;
                            n_cur   = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (w_hit) begin
                    n_cur     = w_row_to;
                    n_matched = 1'b1;
                    n_fsm     = ST_DONE;
                end else if (r_issue == r_count) begin
                    n_fsm = ST_DONE;
                end else begin
                    w_rd_en = 1'b1;
                    n_issue = r_issue + CW'(1);
                end
            end
            ST_DONE: begin
                if (i_res_take) begin
                    n_fsm = ST_IDLE;
                end
            end
            default: begin
                n_fsm = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm   <= ST_IDLE;
            r_cur   <= '0;
            r_count <= '0;
        end else begin
            r_fsm   <= n_fsm;
            r_cur   <= n_cur;
            r_count <= n_count;
        end
    end

    // Scan position, letters and result flags.
    always_ff @(posedge i_clk) begin
        r_issue   <= n_issue;
        r_letter  <= n_letter;
        r_low     <= n_low;
        r_matched <= n_matched;
        r_bad     <= n_bad;
        r_full    <= n_full;
    end

endmodule

>>> rtl/table_driven_fsm_engine.sv
`timescale 1ns / 1ps
// Load, restart, bad-letter and unused-mode beats go from acceptance straight to a finished result.
// Step beats scan the N loaded rows (up to TABLE_DEPTH) in order and stop at the first match.
// One item at a time; the next beat is taken the cycle after the result leaves the engine.
// The row memory has a registered read port and is scanned one row per cycle.
// Synchronous active-low reset clears the row count, current state and handshakes;
// the row memory keeps its contents and needs no clearing pass.

module table_driven_fsm_engine #(
    parameter int TABLE_DEPTH = fsme_pkg::TABLE_DEPTH_DEF,
    parameter int STATE_BITS  = fsme_pkg::STATE_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [23:0]                        i_s_tdata,  // letter, from_state, to_state
    input  logic [fsme_pkg::MODE_W-1:0]        i_s_tuser,  // mode
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [fsme_pkg::OUT_DATA_W-1:0]    o_m_tdata   // new_state, matched,
                                                           // bad_letter, table_full
);

    logic              w_accept;
    logic              w_res_valid;
    logic              w_take;
    fsme_pkg::t_result w_res;
    logic              r_out_valid;
    fsme_pkg::t_result r_out;

    assign w_accept = i_s_tvalid && o_s_tready;

    fsme_engine #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .STATE_BITS  (STATE_BITS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_accept),
        .i_mode      (fsme_pkg::t_mode'(i_s_tuser)),
        .i_letter    (i_s_tdata[7:0]),
        .i_from      (i_s_tdata[15:8]),
        .i_to        (i_s_tdata[23:16]),
        .o_ready     (o_s_tready),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_take  (w_take)
    );

    // Output register: takes a result whenever it is empty or being drained.
    assign w_take = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid && w_take) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_take) begin
            r_out <= w_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(fsme_pkg::OUT_DATA_W - fsme_pkg::RESULT_W){1'b0}}, r_out};

    // At most one outcome flag per result beat.
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> $onehot0({r_out.matched, r_out.bad_letter, r_out.table_full}))
        else $error("more than one outcome flag set");

    // The engine works on one item at a time.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_s_tready)
        else $error("beat accepted while an item is in progress");

    // A finished result waits in the engine until the output register has room.
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_valid && !w_take) |=> w_res_valid)
        else $error("result dropped while the output register was full");

endmodule

>>> verif/table_driven_fsm_engine_test.sv
`timescale 1ns / 1ps

module table_driven_fsm_engine_test;

    localparam int DEPTH        = fsme_pkg::TABLE_DEPTH_DEF;
    localparam int TARGET_ITEMS = 650;
    localparam int PHASE_LEN    = 60;
    localparam int DRAIN_CYCLES = DEPTH + 16;
    localparam int MW           = fsme_pkg::MODE_W;

    // The one mode code that the package leaves without a name.
    localparam logic [MW-1:0] MODE_UNUSED = 2'd3;

    // Idling phases, cycled through as beats are taken.
    localparam int PH_NONE     = 0;
    localparam int PH_SENDER   = 1;
    localparam int PH_RECEIVER = 2;
    localparam int PH_BOTH     = 3;

    typedef struct packed {
        logic [MW-1:0] mode;
        logic [7:0]    letter;
        logic [7:0]    from_st;
        logic [7:0]    to_st;
    } t_fsm_item;

    logic                            i_clk      = 1'b0;
    logic                            i_rst_n    = 1'b0;
    logic                            i_s_tvalid = 1'b0;
    logic                            o_s_tready;
    logic [23:0]                     i_s_tdata  = '0;   // letter, from_state, to_state
    logic [MW-1:0]                   i_s_tuser  = '0;   // mode
    logic                            o_m_tvalid;
    logic                            i_m_tready = 1'b0;
    logic [fsme_pkg::OUT_DATA_W-1:0] o_m_tdata;  // new_state, matched, bad_letter, table_full

    table_driven_fsm_engine uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // Stimulus waiting to be sent and results waiting to arrive.
    t_fsm_item         stim_items[$];
    fsme_pkg::t_result predicted_results[$];
    t_fsm_item         cur_item;

    // Our own copy of the transition table and the machine state.
    logic [7:0] row_from   [DEPTH];
    logic [7:0] row_letter [DEPTH];
    logic [7:0] row_to     [DEPTH];
    int         row_count  = 0;
    logic [7:0] cur_state  = '0;

    int idle_phase   = PH_NONE;
    int items_sent   = 0;
    int beats_seen   = 0;
    int error_count  = 0;
    int n_loads      = 0;
    int n_full       = 0;
    int n_steps      = 0;
    int n_matched    = 0;
    int n_bad        = 0;
    int n_restarts   = 0;

    // Clock generation.
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // A letter is A-Z or a-z; setting the case bit maps both ranges onto a-z.
    function automatic bit is_alpha(input logic [7:0] c);
        logic [7:0] folded;
        folded = c | fsme_pkg::CASE_OFFSET;
        return (folded >= fsme_pkg::CH_LOWER_A) && (folded <= fsme_pkg::CH_LOWER_Z);
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return ((c >= fsme_pkg::CH_UPPER_A) && (c <= fsme_pkg::CH_UPPER_Z)) ?
               (c | fsme_pkg::CASE_OFFSET) : c;
    endfunction

    // Applies one accepted beat to the machine and queues the result it gives.
    task automatic apply_to_machine(input t_fsm_item it);
        fsme_pkg::t_result r;
        logic [7:0]        low;
        bit                hit;
        r   = '0;
        hit = 1'b0;
        case (it.mode)
            fsme_pkg::MODE_LOAD: begin
                if (row_count < DEPTH) begin
                    row_from[row_count]   = it.from_st;
                    row_letter[row_count] = it.letter;
                    row_to[row_count]     = it.to_st;
                    row_count++;
                end else begin
                    r.table_full = 1'b1;
                end
            end
            fsme_pkg::MODE_STEP: begin
                if (!is_alpha(it.letter)) begin
                    r.bad_letter = 1'b1;
                end else begin
                    low = to_lower(it.letter);
                    // First matching row wins; rows keep the case they were loaded with.
                    for (int i = 0; i < row_count && !hit; i++) begin
                        if (row_from[i] == cur_state &&
                            (row_letter[i] == it.letter || row_letter[i] == low)) begin
                            cur_state = row_to[i];
                            hit       = 1'b1;
                        end
                    end
                    r.matched = hit;
                end
            end
            fsme_pkg::MODE_RESTART: begin
                row_count = 0;
                cur_state = '0;
            end
            default: begin
            end
        endcase
        r.new_state = cur_state;
        predicted_results.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH at result %0d: %s got 0x%0h, expected 0x%0h",
                 beats_seen, what, got, want);
        error_count++;
    endtask

    task automatic add_item(input logic [MW-1:0] mode, input logic [7:0] letter,
                            input logic [7:0] from_st, input logic [7:0] to_st);
        t_fsm_item it;
        it.mode    = mode;
        it.letter  = letter;
        it.from_st = from_st;
        it.to_st   = to_st;
        stim_items.push_back(it);
    endtask

    // A letter from a small alphabet in either case, so that rows get hit often.
    function automatic logic [7:0] pick_letter();
        logic [7:0] c;
        c = fsme_pkg::CH_LOWER_A + 8'($urandom_range(0, 3));
        if ($urandom_range(0, 1) == 1) begin
            c = c - fsme_pkg::CASE_OFFSET;
        end
        return c;
    endfunction

    function automatic logic [7:0] pick_non_letter();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(0, 255));
        end while (is_alpha(c));
        return c;
    endfunction

    // Mostly a handful of states so that chains form, now and then any state.
    function automatic logic [7:0] pick_state();
        if ($urandom_range(0, 9) == 0) begin
            return 8'($urandom_range(0, 255));
        end
        return 8'($urandom_range(0, 3));
    endfunction

    function automatic logic [7:0] rnd8();
        return 8'($urandom_range(0, 255));
    endfunction

    // Short directed run: case folding, first-match order, exact upper-case rows,
    // non-letters at the edges of both ranges, the unused mode and the field extremes.
    task automatic build_directed();
        add_item(fsme_pkg::MODE_RESTART, 8'hFF, 8'hFF, 8'hFF);
        add_item(fsme_pkg::MODE_STEP,    fsme_pkg::CH_LOWER_A, 8'h00, 8'hFF);
        add_item(fsme_pkg::MODE_LOAD,    fsme_pkg::CH_LOWER_A, 8'd0,  8'd1);
        add_item(fsme_pkg::MODE_LOAD,    8'h42,                8'd1,  8'd2);
        add_item(fsme_pkg::MODE_LOAD,    8'h62,                8'd1,  8'd3);
        add_item(fsme_pkg::MODE_LOAD,    fsme_pkg::CH_LOWER_A, 8'd0,  8'd5);
        add_item(fsme_pkg::MODE_LOAD,    fsme_pkg::CH_LOWER_Z, 8'd2,  8'hFF);
        add_item(fsme_pkg::MODE_LOAD,    fsme_pkg::CH_UPPER_Z, 8'hFF, 8'h00);
        add_item(fsme_pkg::MODE_LOAD,    8'h00,                8'd3,  8'd3);
        add_item(fsme_pkg::MODE_STEP,    fsme_pkg::CH_UPPER_A, 8'h00, 8'h00);
        add_item(fsme_pkg::MODE_STEP,    8'h42,                8'hFF, 8'hFF);
        add_item(fsme_pkg::MODE_STEP,    fsme_pkg::CH_LOWER_Z, 8'h00, 8'h00);
        add_item(fsme_pkg::MODE_STEP,    fsme_pkg::CH_LOWER_Z, 8'h00, 8'h00);
        add_item(fsme_pkg::MODE_STEP,    fsme_pkg::CH_UPPER_Z, 8'h00, 8'h00);
        add_item(fsme_pkg::MODE_STEP,    fsme_pkg::CH_LOWER_A, 8'h00, 8'h00);
        add_item(fsme_pkg::MODE_STEP,    8'h62,                8'h00, 8'h00);
        add_item(fsme_pkg::MODE_STEP,    fsme_pkg::CH_UPPER_A - 8'd1, 8'h00, 8'h00);
        add_item(fsme_pkg::MODE_STEP,    fsme_pkg::CH_UPPER_Z + 8'd1, 8'h00, 8'h00);
        add_item(fsme_pkg::MODE_STEP,    fsme_pkg::CH_LOWER_A - 8'd1, 8'h00, 8'h00);
        add_item(fsme_pkg::MODE_STEP,    fsme_pkg::CH_LOWER_Z + 8'd1, 8'h00, 8'h00);
        add_item(fsme_pkg::MODE_STEP,    8'hFF, 8'hFF, 8'hFF);
        add_item(fsme_pkg::MODE_STEP,    8'h00, 8'h00, 8'h00);
        add_item(MODE_UNUSED,            8'hFF, 8'hFF, 8'hFF);
        add_item(fsme_pkg::MODE_STEP,    fsme_pkg::CH_UPPER_A, 8'h00, 8'h00);
        add_item(fsme_pkg::MODE_RESTART, 8'h00, 8'h00, 8'h00);
    endtask

    // Random part: mostly a restart, a small table and a walk through it; some
    // noise and interrupted walks; once, a table filled to the brim and overfilled.
    task automatic build_random();
        int  kind;
        int  rows;
        int  walk;
        int  pick;
        bit  filled;
        filled = 1'b0;
        while (stim_items.size() < TARGET_ITEMS) begin
            kind = $urandom_range(0, 99);
            if (!filled && stim_items.size() >= 300) begin
                filled = 1'b1;
                add_item(fsme_pkg::MODE_RESTART, rnd8(), rnd8(), rnd8());
                for (int i = 0; i < DEPTH + 3; i++) begin
                    add_item(fsme_pkg::MODE_LOAD, pick_letter(), pick_state(), pick_state());
                end
                for (int i = 0; i < 8; i++) begin
                    add_item(fsme_pkg::MODE_STEP, pick_letter(), rnd8(), rnd8());
                end
                add_item(fsme_pkg::MODE_LOAD, rnd8(), rnd8(), rnd8());
                add_item(fsme_pkg::MODE_STEP, pick_letter(), rnd8(), rnd8());
            end else if (kind < 15) begin
                // Noise: any mode with any field values.
                for (int i = $urandom_range(3, 10); i > 0; i--) begin
                    add_item(2'($urandom_range(0, 3)), rnd8(), rnd8(), rnd8());
                end
            end else begin
                add_item(fsme_pkg::MODE_RESTART, rnd8(), rnd8(), rnd8());
                rows = $urandom_range(1, 12);
                for (int i = 0; i < rows; i++) begin
                    add_item(fsme_pkg::MODE_LOAD, pick_letter(), pick_state(), pick_state());
                end
                walk = $urandom_range(3, 15);
                for (int i = 0; i < walk; i++) begin
                    pick = $urandom_range(0, 99);
                    if (kind >= 85 && i == walk / 2) begin
                        // Interrupted walk: the table is emptied part way through.
                        add_item(fsme_pkg::MODE_RESTART, rnd8(), rnd8(), rnd8());
                    end else if (pick < 75) begin
                        add_item(fsme_pkg::MODE_STEP, pick_letter(), rnd8(), rnd8());
                    end else if (pick < 85) begin
                        add_item(fsme_pkg::MODE_STEP, pick_non_letter(), rnd8(), rnd8());
                    end else if (pick < 90) begin
                        add_item(MODE_UNUSED, rnd8(), rnd8(), rnd8());
                    end else begin
                        add_item(fsme_pkg::MODE_LOAD, pick_letter(), pick_state(),
                                 pick_state());
                    end
                end
            end
        end
    endtask

    function automatic bit sender_pause();
        if (idle_phase == PH_SENDER) return $urandom_range(0, 99) < 82;
        if (idle_phase == PH_BOTH)   return $urandom_range(0, 99) < 28;
        return 1'b0;
    endfunction

    function automatic bit receiver_pause();
        if (idle_phase == PH_RECEIVER) return $urandom_range(0, 99) < 82;
        if (idle_phase == PH_BOTH)     return $urandom_range(0, 99) < 28;
        return 1'b0;
    endfunction

    // Driver: presents queued items, predicts each one as its beat is taken.
    always @(posedge i_clk) begin
        bit accepted;
        accepted = i_s_tvalid && o_s_tready;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (accepted) begin
                apply_to_machine(cur_item);
                items_sent++;
            end
            idle_phase <= (items_sent / PHASE_LEN) % 4;
            if (!i_s_tvalid || accepted) begin
                if (stim_items.size() > 0 && !sender_pause()) begin
                    cur_item   = stim_items.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= {cur_item.to_st, cur_item.from_st, cur_item.letter};
                    i_s_tuser  <= cur_item.mode;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result beat against the oldest prediction.
    always @(posedge i_clk) begin
        fsme_pkg::t_result got;
        fsme_pkg::t_result want;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                got = fsme_pkg::t_result'(o_m_tdata[fsme_pkg::RESULT_W-1:0]);
                if (predicted_results.size() == 0) begin
                    report_mismatch("unexpected result beat", int'(got), 0);
                end else begin
                    want = predicted_results.pop_front();
                    if (got.new_state !== want.new_state)
                        report_mismatch("new_state", int'(got.new_state),
                                        int'(want.new_state));
                    if (got.matched !== want.matched)
                        report_mismatch("matched", int'(got.matched), int'(want.matched));
                    if (got.bad_letter !== want.bad_letter)
                        report_mismatch("bad_letter", int'(got.bad_letter),
                                        int'(want.bad_letter));
                    if (got.table_full !== want.table_full)
                        report_mismatch("table_full", int'(got.table_full),
                                        int'(want.table_full));
                    n_matched += int'(want.matched);
                    n_bad     += int'(want.bad_letter);
                    n_full    += int'(want.table_full);
                end
                beats_seen++;
            end
            i_m_tready <= !receiver_pause();
        end
    end

    // Tally what was sent, by mode, as beats are taken.
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            case (i_s_tuser)
                fsme_pkg::MODE_LOAD:    n_loads++;
                fsme_pkg::MODE_STEP:    n_steps++;
                fsme_pkg::MODE_RESTART: n_restarts++;
                default: begin
                end
            endcase
        end
    end

    // Main sequence: build the stimulus, release reset, wait for everything to drain.
    initial begin
        build_directed();
        build_random();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (stim_items.size() > 0 || i_s_tvalid || predicted_results.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (predicted_results.size() > 0) begin
            report_mismatch("results never delivered", 0, predicted_results.size());
        end
        $display("Sent %0d beats: %0d loads, %0d steps, %0d restarts, rest unused mode.",
                 items_sent, n_loads, n_steps, n_restarts);
        $display("Results: %0d matched steps, %0d non-letters, %0d loads dropped when full.",
                 n_matched, n_bad, n_full);
        if (error_count == 0) begin
            $display("table_driven_fsm_engine: match");
        end else begin
            $display("table_driven_fsm_engine: mismatch");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #15ms;
        $display("Timed out with %0d results still awaited.", predicted_results.size());
        $display("table_driven_fsm_engine: mismatch");
        $finish;
    end

endmodule

>>> files.f
rtl/fsme_pkg.sv
rtl/fsme_row_mem.sv
rtl/fsme_engine.sv
rtl/table_driven_fsm_engine.sv
verif/table_driven_fsm_engine_test.sv
